[rtl/gray_box_blur_27x27_assert.svh]
// ----------------------------------------------------------------------------
// gray box blur assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GRAY_BOX_BLUR_27X27_ASSERT_SVH
`define GRAY_BOX_BLUR_27X27_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define GBB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("gbb assertion failed");
// consequent must hold on the clock after the antecedent
`define GBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gbb assertion failed");
`else
`define GBB_ASSERT(label, clk, rst_n, prop)
`define GBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/gbb_pkg.sv]
// ----------------------------------------------------------------------------
// gbb_pkg
// shared types and constants of the gray box blur
// ----------------------------------------------------------------------------
package gbb_pkg;

	localparam int CFG_W     = 12;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
	localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd4095;

	// luma weights, 16 fractional bits
	localparam logic [15:0] COEF_R = 16'd19661;
	localparam logic [15:0] COEF_G = 16'd38666;
	localparam logic [15:0] COEF_B = 16'd6554;

	// per item flags that travel with the column and window sums
	typedef struct packed {
		logic pix;        // pixel item in this slot
		logic row_first;  // first row of the frame
		logic row_full;   // row slot already holds an older row
		logic col_first;  // first column of the row
		logic col_full;   // window span of columns already pushed
	} gbb_ctl_t;

	function automatic logic [PIX_W-1:0] rgb_to_gray(
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] r
	);
		logic [23:0] acc;
		acc = 24'(COEF_R) * 24'(r) + 24'(COEF_G) * 24'(g) + 24'(COEF_B) * 24'(b);
		return acc[23:16];
	endfunction

endpackage

[rtl/gbb_line_store.sv]
// ----------------------------------------------------------------------------
// gbb_line_store
// ring of gray rows, one write and two registered reads per cycle
// ----------------------------------------------------------------------------
module gbb_line_store #(
	parameter int ROWS = 27,
	parameter int COLS = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(ROWS)-1:0]  wr_slot,
	input  logic [$clog2(COLS)-1:0]  wr_col,
	input  logic [gbb_pkg::PIX_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(ROWS)-1:0]  rd_a_slot,
	input  logic [$clog2(COLS)-1:0]  rd_a_col,
	output logic [gbb_pkg::PIX_W-1:0] rd_a_data,
	input  logic [$clog2(ROWS)-1:0]  rd_b_slot,
	input  logic [$clog2(COLS)-1:0]  rd_b_col,
	output logic [gbb_pkg::PIX_W-1:0] rd_b_data
);
	import gbb_pkg::*;

	logic [PIX_W-1:0] mem [ROWS][COLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot][wr_col] <= wr_data;
		end
	end

	// reads return the contents before a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_data <= mem[rd_a_slot][rd_a_col];
			rd_b_data <= mem[rd_b_slot][rd_b_col];
		end
	end

endmodule

[rtl/gbb_colsum_mem.sv]
// ----------------------------------------------------------------------------
// gbb_colsum_mem
// per column running sums, one write and one registered read
// ----------------------------------------------------------------------------
module gbb_colsum_mem #(
	parameter int DEPTH = 2048,
	parameter int W     = 13
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]             rd_data
);
	import gbb_pkg::*;

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/gbb_cell.sv]
// ----------------------------------------------------------------------------
// gbb_cell
// one column sum slot of the window chain
// ----------------------------------------------------------------------------
module gbb_cell #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	import gbb_pkg::*;

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

[rtl/gbb_window.sv]
// ----------------------------------------------------------------------------
// gbb_window
// chain of column sum cells and the running horizontal window sum
// ----------------------------------------------------------------------------
module gbb_window #(
	parameter int CELLS = 27,
	parameter int CSW   = 13,
	parameter int SUMW  = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gbb_pkg::gbb_ctl_t ctl,
	input  logic [CSW-1:0]    cs_in,
	output logic [SUMW-1:0]   win_sum
);
	import gbb_pkg::*;

	logic [CSW-1:0]  chain [CELLS];
	logic            shift;
	logic [SUMW-1:0] win_q;
	logic [SUMW-1:0] win_base;
	logic [SUMW-1:0] win_drop;

	assign shift = en && ctl.pix;

	// cell i holds the column sum pushed i+1 pixels ago
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			gbb_cell #(.W(CSW)) u_cell (
				.clk  (clk),
				.shift(shift),
				.d    (cs_in),
				.q    (chain[i])
			);
		end else begin : g_body
			gbb_cell #(.W(CSW)) u_cell (
				.clk  (clk),
				.shift(shift),
				.d    (chain[i-1]),
				.q    (chain[i])
			);
		end
	end

	assign win_base = ctl.col_first ? '0 : win_q;
	assign win_drop = ctl.col_full ? SUMW'(chain[CELLS-1]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= win_base + SUMW'(cs_in) - win_drop;
		end
	end

	assign win_sum = win_q;

endmodule

[rtl/gray_box_blur_27x27.sv]
// ----------------------------------------------------------------------------
// gray_box_blur_27x27
// streaming gray conversion and square box blur over raster pixels
// ----------------------------------------------------------------------------
// Takes one pixel or flush item per clock while in_stall is low and gives
// back at most one gray result per item. Each pixel becomes floor(0.3r +
// 0.59g + 0.1b); pixels inside the border band keep that value, all others
// become the mean of their square window. Results trail the input by
// HALF_WINDOW rows plus HALF_WINDOW pixels; after the last pixel of a frame,
// flush items drain the trailing border results one per item. The sustained
// rate is one item per clock, set by the line store, which takes one write
// and two reads each cycle, and the column sum memory, which is read in one
// stage and written back in the next. The line store and column sums need no
// clearing pass after reset. Input stall rises only while a result waits in
// the output register and the output side stalls.
// ----------------------------------------------------------------------------
`include "gray_box_blur_27x27_assert.svh"

module gray_box_blur_27x27 #(
	parameter int MAX_WIDTH   = 2048,
	parameter int HALF_WINDOW = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbb_pkg::CFG_W-1:0]     cfg_data,
	// pixel input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [gbb_pkg::PIX_W-1:0]     blue,
	input  logic [gbb_pkg::PIX_W-1:0]     green,
	input  logic [gbb_pkg::PIX_W-1:0]     red,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gbb_pkg::PIX_W-1:0]     gray_out,
	output logic                          frame_end
);
	import gbb_pkg::*;

	localparam int H        = HALF_WINDOW;
	localparam int WIN      = 2 * H + 1;
	localparam int MIN_SIZE = 2 * H + 2;
	localparam int SLOTW    = $clog2(WIN);
	localparam int COLW     = $clog2(MAX_WIDTH);
	localparam int CSW      = $clog2(WIN * 255 + 1);
	localparam int DIV      = WIN * WIN;
	localparam int SUMW     = $clog2(DIV * 255 + 1);
	// reciprocal of the window area, exact floor for every reachable sum
	localparam int RK       = SUMW + $clog2(DIV);
	localparam longint unsigned RECIP = ((64'd1 << RK) + DIV - 1) / DIV;
	localparam int RECW     = $clog2(RECIP + 1);
	localparam int PW       = SUMW + RECW;

	// ------------------------------------------------------------------
	// configuration registers; the user writes them only while idle, the block does not enforce it
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// sizes saturated into the supported range
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (int'(width_q) < MIN_SIZE) begin
			w_eff = CFG_W'(MIN_SIZE);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (int'(height_q) < MIN_SIZE) begin
			h_eff = CFG_W'(MIN_SIZE);
		end else if (height_q > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = height_q;
		end
	end

	// ------------------------------------------------------------------
	// handshake: the whole pipe advances unless a result is held
	// ------------------------------------------------------------------
	logic en;
	logic in_acc;
	logic out_valid_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;
	assign in_acc   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// position tracking for input and output pixels
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] in_row_q, in_col_q;
	logic [SLOTW-1:0] in_slot_q;
	logic [CFG_W-1:0] o_row_q, o_col_q;
	logic [SLOTW-1:0] o_slot_q;

	logic [CFG_W-1:0] in_row_nxt, in_col_nxt;
	logic [SLOTW-1:0] in_slot_nxt;
	logic [CFG_W-1:0] o_row_nxt, o_col_nxt;
	logic [SLOTW-1:0] o_slot_nxt;

	logic [CFG_W-1:0] rr, cc;          // position of this pixel after wrap
	logic [SLOTW-1:0] rslot;
	logic [CFG_W-1:0] orow, ocol;      // output pixel to emit
	logic [SLOTW-1:0] oslot;
	logic [CFG_W-1:0] tr, tc;          // output position this pixel completes
	logic             frame_rcvd;
	logic             over;
	logic             started;
	logic             is_pix;
	logic             do_emit;
	logic             border;
	logic             last_out;

	always_comb begin
		in_row_nxt  = in_row_q;
		in_col_nxt  = in_col_q;
		in_slot_nxt = in_slot_q;
		o_row_nxt   = o_row_q;
		o_col_nxt   = o_col_q;
		o_slot_nxt  = o_slot_q;
		rr          = in_row_q;
		cc          = in_col_q;
		rslot       = in_slot_q;
		orow        = o_row_q;
		ocol        = o_col_q;
		oslot       = o_slot_q;
		tr          = '0;
		tc          = '0;
		started     = 1'b0;
		is_pix      = 1'b0;
		do_emit     = 1'b0;
		border      = 1'b0;
		last_out    = 1'b0;

		frame_rcvd = (in_row_q == '0) && (in_col_q == '0) &&
			((o_row_q != '0) || (o_col_q != '0));
		over = (o_row_q >= h_eff) || (o_col_q >= w_eff);

		if (over) begin
			// output counter beyond a shrunken frame: drop it silently
			o_row_nxt  = '0;
			o_col_nxt  = '0;
			o_slot_nxt = '0;
		end else if (op == OP_FLUSH) begin
			do_emit = frame_rcvd;
		end else begin
			is_pix = 1'b1;
			// new frame before drain drops the pending outputs
			if (frame_rcvd) begin
				orow  = '0;
				ocol  = '0;
				oslot = '0;
			end
			if (rr >= h_eff) begin
				rr    = '0;
				rslot = '0;
			end
			if (cc >= w_eff) begin
				cc = '0;
			end
			if (cc == w_eff - 1'b1) begin
				in_col_nxt = '0;
				if (rr + 1'b1 >= h_eff) begin
					in_row_nxt  = '0;
					in_slot_nxt = '0;
				end else begin
					in_row_nxt  = rr + 1'b1;
					in_slot_nxt = (rslot == SLOTW'(WIN - 1)) ? '0 : rslot + 1'b1;
				end
			end else begin
				in_col_nxt  = cc + 1'b1;
				in_row_nxt  = rr;
				in_slot_nxt = rslot;
			end
			started = (rr > CFG_W'(H)) || ((rr == CFG_W'(H)) && (cc >= CFG_W'(H)));
			if (cc >= CFG_W'(H)) begin
				tr = rr - CFG_W'(H);
				tc = cc - CFG_W'(H);
			end else begin
				tr = rr - CFG_W'(H + 1);
				tc = cc + w_eff - CFG_W'(H);
			end
			do_emit = started && ((orow < tr) || ((orow == tr) && (ocol <= tc)));
			o_row_nxt  = orow;
			o_col_nxt  = ocol;
			o_slot_nxt = oslot;
		end

		if (do_emit) begin
			border = (orow <= CFG_W'(H)) || (ocol <= CFG_W'(H)) ||
				({1'b0, orow} + (CFG_W + 1)'(H) >= {1'b0, h_eff}) ||
				({1'b0, ocol} + (CFG_W + 1)'(H) >= {1'b0, w_eff});
			if (ocol >= w_eff - 1'b1) begin
				last_out = (orow >= h_eff - 1'b1);
				o_col_nxt = '0;
				if (last_out) begin
					o_row_nxt  = '0;
					o_slot_nxt = '0;
				end else begin
					o_row_nxt  = orow + 1'b1;
					o_slot_nxt = (oslot == SLOTW'(WIN - 1)) ? '0 : oslot + 1'b1;
				end
			end else begin
				o_col_nxt  = ocol + 1'b1;
				o_row_nxt  = orow;
				o_slot_nxt = oslot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_slot_q <= '0;
			o_row_q   <= '0;
			o_col_q   <= '0;
			o_slot_q  <= '0;
		end else if (in_acc) begin
			in_row_q  <= in_row_nxt;
			in_col_q  <= in_col_nxt;
			in_slot_q <= in_slot_nxt;
			o_row_q   <= o_row_nxt;
			o_col_q   <= o_col_nxt;
			o_slot_q  <= o_slot_nxt;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: gray value and addresses
	// ------------------------------------------------------------------
	gbb_ctl_t         ctl_s0;
	gbb_ctl_t         ctl_s1, ctl_s2, ctl_s3;
	logic             emit_s1, emit_s2, emit_s3, emit_s4, emit_s5;
	logic             border_s1, border_s2, border_s3, border_s4, border_s5;
	logic             fe_s1, fe_s2, fe_s3, fe_s4, fe_s5;
	logic [PIX_W-1:0] gray_s1, gray_s2;
	logic [CFG_W-1:0] col_s1, col_s2;
	logic [SLOTW-1:0] slot_s1;
	logic [CFG_W-1:0] ocol_s1;
	logic [SLOTW-1:0] oslot_s1;

	always_comb begin
		ctl_s0.pix       = in_acc && is_pix;
		ctl_s0.row_first = (rr == '0);
		ctl_s0.row_full  = (rr >= CFG_W'(WIN));
		ctl_s0.col_first = (cc == '0);
		ctl_s0.col_full  = (cc >= CFG_W'(WIN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			emit_s1 <= 1'b0;
		end else if (en) begin
			ctl_s1  <= ctl_s0;
			emit_s1 <= in_acc && do_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_s1   <= rgb_to_gray(blue, green, red);
			col_s1    <= cc;
			slot_s1   <= rslot;
			ocol_s1   <= ocol;
			oslot_s1  <= oslot;
			border_s1 <= border;
			fe_s1     <= last_out;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: line store and column sum reads come back
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] old_s2;    // gray value leaving the column window
	logic [PIX_W-1:0] bval_s2;   // stored gray for border outputs
	logic [CSW-1:0]   csrd_s2;
	logic [CSW-1:0]   cs_new;

	gbb_line_store #(.ROWS(WIN), .COLS(MAX_WIDTH)) u_line_store (
		.clk      (clk),
		.wr_en    (en && ctl_s1.pix),
		.wr_slot  (slot_s1),
		.wr_col   (COLW'(col_s1)),
		.wr_data  (gray_s1),
		.rd_en    (en),
		.rd_a_slot(slot_s1),
		.rd_a_col (COLW'(col_s1)),
		.rd_a_data(old_s2),
		.rd_b_slot(oslot_s1),
		.rd_b_col (COLW'(ocol_s1)),
		.rd_b_data(bval_s2)
	);

	gbb_colsum_mem #(.DEPTH(MAX_WIDTH), .W(CSW)) u_colsum (
		.clk    (clk),
		.wr_en  (en && ctl_s2.pix),
		.wr_addr(COLW'(col_s2)),
		.wr_data(cs_new),
		.rd_en  (en),
		.rd_addr(COLW'(col_s1)),
		.rd_data(csrd_s2)
	);

	// column sum over the last window of rows, restarted on the first row
	assign cs_new = (ctl_s2.row_first ? '0 : csrd_s2) + CSW'(gray_s2) -
		(ctl_s2.row_full ? CSW'(old_s2) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			emit_s2 <= 1'b0;
		end else if (en) begin
			ctl_s2  <= ctl_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_s2   <= gray_s1;
			col_s2    <= col_s1;
			border_s2 <= border_s1;
			fe_s2     <= fe_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: column sum enters the cell chain
	// ------------------------------------------------------------------
	logic [CSW-1:0]   cs_s3;
	logic [PIX_W-1:0] bval_s3, bval_s4, bval_s5;
	logic [SUMW-1:0]  win_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3  <= '0;
			emit_s3 <= 1'b0;
		end else if (en) begin
			ctl_s3  <= ctl_s2;
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s3     <= cs_new;
			bval_s3   <= bval_s2;
			border_s3 <= border_s2;
			fe_s3     <= fe_s2;
		end
	end

	gbb_window #(.CELLS(WIN), .CSW(CSW), .SUMW(SUMW)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl    (ctl_s3),
		.cs_in  (cs_s3),
		.win_sum(win_sum)
	);

	// ------------------------------------------------------------------
	// stage 4 and 5: divide by the window area through the reciprocal
	// ------------------------------------------------------------------
	logic [PW-1:0]    prod_s5;
	logic [PIX_W-1:0] quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s4 <= 1'b0;
			emit_s5 <= 1'b0;
		end else if (en) begin
			emit_s4 <= emit_s3;
			emit_s5 <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bval_s4   <= bval_s3;
			border_s4 <= border_s3;
			fe_s4     <= fe_s3;
			prod_s5   <= PW'(win_sum) * PW'(RECIP);
			bval_s5   <= bval_s4;
			border_s5 <= border_s4;
			fe_s5     <= fe_s4;
		end
	end

	assign quot = PIX_W'(prod_s5 >> RK);

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] gray_out_q;
	logic             frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= emit_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_out_q  <= border_s5 ? bval_s5 : quot;
			frame_end_q <= fe_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign gray_out  = gray_out_q;
	assign frame_end = frame_end_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`GBB_ASSERT(a_slots_in_range, clk, arst_n, (in_slot_q < SLOTW'(WIN)) && (o_slot_q < SLOTW'(WIN)))
	`GBB_ASSERT_NEXT(a_hold_freezes_window, clk, arst_n, out_valid_q && out_stall, $stable(win_sum))
	`GBB_ASSERT_NEXT(a_restart_clears_out, clk, arst_n, in_acc && (op == OP_PIXEL) && frame_rcvd, (o_row_q == '0) && (o_col_q == '0))

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming gray box blur
// ----------------------------------------------------------------------------
// A queue of pixel, flush and register-write steps is filled up front. A
// clocked driver feeds it to the block with random gaps, a clocked monitor
// takes results with random stalls. Every accepted item runs through a local
// model of the blur (line store of gray bytes, input position, output index),
// and each result is checked against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_top;
	import gbb_pkg::*;

	localparam int HALF    = 13;
	localparam int SIDE    = 2 * HALF + 1;
	localparam int MAX_W   = 2048;
	localparam int MIN_DIM = 2 * HALF + 2;
	localparam int SETTLE  = 12;  // cycles of quiet before a register write

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

	typedef struct {
		step_kind_e         kind;
		logic               op;
		logic [PIX_W-1:0]   b, g, r;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]   data;
		int                 gap;
		bit                 calm;
	} step_t;

	typedef struct {
		logic [PIX_W-1:0] gray;
		logic             last;
	} blur_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all changed at the falling edge
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 op = OP_PIXEL;
	logic [PIX_W-1:0]     blue = '0, green = '0, red = '0;
	logic                 out_stall = 1'b0;

	logic                 cfg_ready, in_stall, out_valid, frame_end;
	logic [PIX_W-1:0]     gray_out;

	// values computed at the rising edge, put on the ports at the falling one
	logic                 nx_cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] nx_cfg_index = '0;
	logic [CFG_W-1:0]     nx_cfg_data = '0;
	logic                 nx_in_valid = 1'b0;
	logic                 nx_op = OP_PIXEL;
	logic [PIX_W-1:0]     nx_blue = '0, nx_green = '0, nx_red = '0;
	logic                 nx_out_stall = 1'b0;

	step_t       steps[$];
	blur_pixel_t pending_pixels[$];

	// blur model state
	byte unsigned line_rows[SIDE][MAX_W];
	int unsigned  row_at, col_at, out_at;
	logic [CFG_W-1:0] reg_width, reg_height;

	int  mismatches = 0;
	int  pixel_count = 0, flush_count = 0, result_count = 0, frame_count = 0;
	int  item_total = 0;
	bit  fill_done = 1'b0;
	bit  calm_now = 1'b0;     // no gaps, no stalls for this stretch
	bit  fill_calm = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  quiet = 0;

	gray_box_blur_27x27 dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .blue(blue), .green(green), .red(red),
		.out_valid(out_valid), .out_stall(out_stall),
		.gray_out(gray_out), .frame_end(frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic int unsigned frame_w();
		int unsigned w;
		w = reg_width;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int unsigned frame_h();
		int unsigned h;
		h = reg_height;
		if (h < MIN_DIM) h = MIN_DIM;
		return h;  // 12-bit register never exceeds the height ceiling
	endfunction

	function automatic bit frame_complete();
		return row_at == 0 && col_at == 0 && out_at != 0;
	endfunction

	// produce output pixel out_at: border passes through, interior is the mean
	function automatic void emit_pixel(int unsigned w, int unsigned h);
		int unsigned rr, cc, acc;
		blur_pixel_t px;
		rr = out_at / w;
		cc = out_at % w;
		if (rr <= HALF || rr + HALF >= h || cc <= HALF || cc + HALF >= w) begin
			px.gray = line_rows[rr % SIDE][cc];
		end else begin
			acc = 0;
			for (int i = rr - HALF; i <= rr + HALF; i++)
				for (int j = cc - HALF; j <= cc + HALF; j++)
					acc += line_rows[i % SIDE][j];
			px.gray = acc / (SIDE * SIDE);
		end
		out_at++;
		px.last = 1'b0;
		if (out_at >= w * h) begin
			px.last = 1'b1;
			out_at = 0;
		end
		pending_pixels.push_back(px);
	endfunction

	function automatic void blur_predict(logic is_flush, logic [7:0] b, logic [7:0] g,
			logic [7:0] r);
		int unsigned w, h, lag, pos, luma;
		w = frame_w();
		h = frame_h();
		lag = HALF * w + HALF;
		if (out_at >= w * h) begin
			out_at = 0;
			return;
		end
		if (is_flush == OP_FLUSH) begin
			if (frame_complete()) emit_pixel(w, h);
			return;
		end
		luma = (19661 * r + 38666 * g + 6554 * b) >> 16;
		if (frame_complete()) out_at = 0;
		if (row_at >= h) row_at = 0;
		if (col_at >= w) col_at = 0;
		line_rows[row_at % SIDE][col_at] = luma;
		pos = row_at * w + col_at;
		col_at++;
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
			if (row_at >= h) row_at = 0;
		end
		if (pos >= lag && out_at <= pos - lag) emit_pixel(w, h);
	endfunction

	// ------------------------------------------------------------ stimulus

	task automatic add_item(logic is_flush, logic [7:0] b, logic [7:0] g, logic [7:0] r);
		step_t s;
		s.kind = STEP_ITEM;
		s.op = is_flush;
		s.b = b; s.g = g; s.r = r;
		s.idx = REG_IMAGE_WIDTH;
		s.data = '0;
		s.gap = fill_calm ? 0 : $urandom_range(0, 8);
		s.calm = fill_calm;
		steps.push_back(s);
		item_total++;
	endtask

	task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		step_t s;
		s.kind = STEP_CFG;
		s.op = OP_PIXEL;
		s.b = '0; s.g = '0; s.r = '0;
		s.idx = idx;
		s.data = value;
		s.gap = 0;
		s.calm = fill_calm;
		steps.push_back(s);
	endtask

	// mode 0: random, 1: all white, 2: mixed with saturated channels
	task automatic add_pixels(int n, int mode);
		logic [7:0] c[3];
		for (int k = 0; k < n; k++) begin
			for (int q = 0; q < 3; q++) begin
				case (mode)
					1: c[q] = 8'hFF;
					2: c[q] = ($urandom_range(0, 3) == 0) ? 8'hFF :
						($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
					default: c[q] = 8'($urandom);
				endcase
			end
			add_item(OP_PIXEL, c[0], c[1], c[2]);
			// stray flush inside a frame yields nothing
			if ($urandom_range(0, 39) == 0)
				add_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic add_drain(int w, bit full);
		int n;
		n = full ? HALF * w + HALF + $urandom_range(0, 3) : $urandom_range(1, HALF * w);
		for (int k = 0; k < n; k++)
			add_item(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int w, h;
		for (int i = 0; i < SIDE; i++)
			for (int j = 0; j < MAX_W; j++)
				line_rows[i][j] = 0;
		row_at = 0; col_at = 0; out_at = 0;
		reg_width = RST_WIDTH;
		reg_height = RST_HEIGHT;

		// directed: corner colors and early flushes at the reset size
		add_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
		add_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		add_item(OP_PIXEL, 8'h00, 8'h00, 8'hFF);
		add_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
		add_item(OP_PIXEL, 8'hFF, 8'h00, 8'h00);
		add_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		add_item(OP_PIXEL, 8'h01, 8'h02, 8'h04);
		add_item(OP_PIXEL, 8'hAA, 8'h55, 8'hAA);
		add_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
		add_item(OP_PIXEL, 8'h80, 8'h40, 8'h20);
		add_item(OP_PIXEL, 8'h7F, 8'hFE, 8'hFD);
		add_item(OP_PIXEL, 8'h10, 8'h08, 8'h01);

		// oversize width saturates to the widest line
		add_reg(REG_IMAGE_WIDTH, 12'd4095);
		add_pixels(40, 0);

		// undersize values clamp to the smallest frame, column wraps to zero
		add_reg(REG_IMAGE_WIDTH, 12'd27);
		add_reg(REG_IMAGE_HEIGHT, 12'd0);
		add_reg(REG_IMAGE_HEIGHT, 12'd4095);
		add_pixels(2 * MIN_DIM, 2);
		add_reg(REG_IMAGE_HEIGHT, 12'd28);
		add_pixels((MIN_DIM - 2) * MIN_DIM, 2);
		add_drain(MIN_DIM, 1'b1);

		// full white frame with no idling: largest window sums
		fill_calm = 1'b1;
		add_reg(REG_IMAGE_WIDTH, 12'd30);
		add_reg(REG_IMAGE_HEIGHT, 12'd29);
		add_pixels(30 * 29, 1);
		add_drain(30, 1'b1);

		// random frames; some are cut short by the next frame's first pixel
		while (item_total < 1700) begin
			fill_calm = ($urandom_range(0, 3) == 0);
			w = $urandom_range(28, 36);
			h = $urandom_range(28, 33);
			add_reg(REG_IMAGE_WIDTH, 12'(w));
			add_reg(REG_IMAGE_HEIGHT, 12'(h));
			add_pixels(w * h, $urandom_range(0, 2));
			add_drain(w, 1'b0);
			add_pixels(w * h, 0);
			add_drain(w, item_total >= 1700 || $urandom_range(0, 1) == 1);
		end
		fill_done = 1'b1;
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		step_t s;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				blur_predict(op, blue, green, red);
				if (op == OP_FLUSH) flush_count++;
				else pixel_count++;
				nx_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) reg_width = cfg_data;
				else reg_height = cfg_data;
				nx_cfg_valid = 1'b0;
			end
			quiet = (pending_pixels.size() == 0) ? quiet + 1 : 0;
			if (!nx_in_valid && !nx_cfg_valid && steps.size() != 0) begin
				s = steps[0];
				calm_now = s.calm;
				if (s.kind == STEP_CFG) begin
					// register writes only once the block has gone quiet
					if (quiet >= SETTLE && !in_valid) begin
						void'(steps.pop_front());
						nx_cfg_valid = 1'b1;
						nx_cfg_index = s.idx;
						nx_cfg_data = s.data;
					end
				end else if (gap_left < s.gap) begin
					gap_left++;
				end else begin
					void'(steps.pop_front());
					gap_left = 0;
					nx_in_valid = 1'b1;
					nx_op = s.op;
					nx_blue = s.b;
					nx_green = s.g;
					nx_red = s.r;
				end
			end
		end
	end

	always @(negedge clk) begin
		cfg_valid <= nx_cfg_valid;
		cfg_index <= nx_cfg_index;
		cfg_data <= nx_cfg_data;
		in_valid <= nx_in_valid;
		op <= nx_op;
		blue <= nx_blue;
		green <= nx_green;
		red <= nx_red;
		out_stall <= nx_out_stall;
	end

	// --------------------------------------------------------------- monitor

	always @(posedge clk) begin
		blur_pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (frame_end) frame_count++;
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: gray %0d frame_end %0b",
							gray_out, frame_end);
				end else begin
					want = pending_pixels.pop_front();
					if (gray_out !== want.gray || frame_end !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected gray %0d end %0b, got gray %0d end %0b",
								result_count, want.gray, want.last, gray_out, frame_end);
					end
				end
				stall_left = calm_now ? 0 : $urandom_range(0, 8);
			end
			nx_out_stall = (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// ------------------------------------------------------------ run control

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		do @(posedge clk);
		while (!(fill_done && steps.size() == 0 && !nx_in_valid && !nx_cfg_valid
			&& pending_pixels.size() == 0));
		repeat (40) @(posedge clk);
		$display("covered %0d pixel and %0d flush transfers, %0d results, %0d frame ends",
			pixel_count, flush_count, result_count, frame_count);
		$display("sizes from clamped minimum to saturated width, with early frame restarts");
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("gray_box_blur_27x27: match");
		else
			$display("gray_box_blur_27x27: mismatch");
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout waiting on the block");
		$display("gray_box_blur_27x27: mismatch");
		$finish;
	end

endmodule
